// ===== rtl/core/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted record table
// Field widths, table depth, operation and status codes, and the structs
// passed between the sequencer, the compare unit and the top level.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam int DEPTH       = 64;
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W       = $clog2(DEPTH + 1);

   localparam int KIND_W      = 2;
   localparam int ENTRY_W     = 6;
   localparam int YEAR_W      = 12;
   localparam int MONTH_W     = 4;
   localparam int AMT_W       = 24;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CHANGE = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_BAD_IDX = 2'd2
   } status_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [AMT_W-1:0]   amount;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // compare unit results
   typedef struct packed {
      logic year_ge;    // entry year >= key year
      logic past_key;   // entry year > key year, or entry month > key month
      logic amt_gt;     // entry amount > running maximum
   } cmp_type;

   // finished request, handed to the output register
   typedef struct packed {
      status_type         status;
      logic [CNT_W-1:0]   count;
      logic [AMT_W-1:0]   max_amount;
      rec_type            rec;
   } res_type;

endpackage

// ===== rtl/core/srt_ram.sv =====
// ----------------------------------------------------------------------------
// srt_ram: record store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srt_ram (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [srt_pkg::IDX_W-1:0] wr_addr,
   input  srt_pkg::rec_type      wr_data,
   input  logic                  rd_en,
   input  logic [srt_pkg::IDX_W-1:0] rd_addr,
   output srt_pkg::rec_type      rd_data
);
   import srt_pkg::*;

   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/srt_cmp.sv =====
// ----------------------------------------------------------------------------
// srt_cmp: shared compare unit
// Compares one stored record against the insert key and the running max.
// ----------------------------------------------------------------------------
module srt_cmp (
   input  srt_pkg::rec_type              rec,
   input  logic [srt_pkg::YEAR_W-1:0]    key_year,
   input  logic [srt_pkg::MONTH_W-1:0]   key_month,
   input  logic [srt_pkg::AMT_W-1:0]     cur_max,
   output srt_pkg::cmp_type              res
);
   import srt_pkg::*;

   always_comb begin
      res.year_ge  = (rec.year >= key_year);
      res.past_key = (rec.year > key_year) || (rec.month > key_month);
      res.amt_gt   = (rec.amount > cur_max);
   end

endmodule

// ===== rtl/core/srt_seq.sv =====
// ----------------------------------------------------------------------------
// srt_seq: operation sequencer
// Walks the record store one entry per cycle for slot search, shifts and
// the max rescan, using one read port, one write port and the compare unit.
// ----------------------------------------------------------------------------
module srt_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srt_pkg::KIND_W-1:0]    req_kind,
   input  logic [srt_pkg::ENTRY_W-1:0]   req_entry_index,
   input  logic [srt_pkg::YEAR_W-1:0]    req_rec_year,
   input  logic [srt_pkg::MONTH_W-1:0]   req_rec_month,
   input  logic [srt_pkg::AMT_W-1:0]     req_rec_amount,
   input  logic                          out_free,
   output logic                          done,
   output srt_pkg::res_type              result
);
   import srt_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_FIND = 8'b0000_0010,
      S_SHUP = 8'b0000_0100,
      S_NEW  = 8'b0000_1000,
      S_SHDN = 8'b0001_0000,
      S_SCAN = 8'b0010_0000,
      S_RDW  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [AMT_W-1:0]   max_ff, max_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   rec_type            new_ff, new_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic               iss_ff, iss_in;
   logic               dv_ff, dv_in;
   logic [IDX_W-1:0]   dptr_ff, dptr_in;
   logic               in_run_ff, in_run_in;
   status_type         status_ff, status_in;
   rec_type            rd_rec_ff, rd_rec_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   rec_type            wr_data;
   rec_type            rd_data;
   cmp_type            cmp;

   logic               accept;
   kind_type           kind;
   rec_type            req_rec;
   logic [CNT_W-1:0]   last_cnt;
   logic               ptr_last;
   logic               dptr_last;
   logic               bad_idx;

   srt_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (iss_ff),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   srt_cmp u_cmp (
      .rec       (rd_data),
      .key_year  (new_ff.year),
      .key_month (new_ff.month),
      .cur_max   (max_ff),
      .res       (cmp)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign kind      = kind_type'(req_kind);
   assign last_cnt  = count_ff - CNT_W'(1);
   assign ptr_last  = (CNT_W'(ptr_ff) == last_cnt);
   assign dptr_last = (CNT_W'(dptr_ff) == last_cnt);
   assign bad_idx   = (32'(req_entry_index) >= 32'(count_ff));
   assign done      = (state_ff == S_DONE) && out_free;

   always_comb begin
      req_rec.year   = req_rec_year;
      req_rec.month  = req_rec_month;
      req_rec.amount = req_rec_amount;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      max_in    = max_ff;
      idx_in    = idx_ff;
      new_in    = new_ff;
      pos_in    = pos_ff;
      ptr_in    = ptr_ff;
      iss_in    = iss_ff;
      in_run_in = in_run_ff;
      status_in = status_ff;
      rd_rec_in = rd_rec_ff;
      wr_en     = 1'b0;
      wr_addr   = ptr_ff;
      wr_data   = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = STAT_OK;
               rd_rec_in = '0;
               new_in    = req_rec;
               idx_in    = IDX_W'(req_entry_index);
               if (kind == KIND_INSERT) begin
                  if (32'(count_ff) >= 32'(DEPTH)) begin
                     status_in = STAT_FULL;
                     state_in  = S_DONE;
                  end else if (count_ff == '0) begin
                     pos_in   = '0;
                     state_in = S_NEW;
                  end else begin
                     ptr_in    = '0;
                     iss_in    = 1'b1;
                     in_run_in = 1'b0;
                     state_in  = S_FIND;
                  end
               end else if (bad_idx) begin
                  status_in = STAT_BAD_IDX;
                  state_in  = S_DONE;
               end else begin
                  case (kind)
                     KIND_DELETE: begin
                        if (32'(req_entry_index) + 32'd1 == 32'(count_ff)) begin
                           // last entry: nothing to shift
                           count_in = last_cnt;
                           if (last_cnt == '0) begin
                              max_in   = '0;
                              state_in = S_DONE;
                           end else begin
                              max_in   = '0;
                              ptr_in   = '0;
                              iss_in   = 1'b1;
                              state_in = S_SCAN;
                           end
                        end else begin
                           ptr_in   = IDX_W'(req_entry_index) + IDX_W'(1);
                           iss_in   = 1'b1;
                           state_in = S_SHDN;
                        end
                     end
                     KIND_CHANGE: begin
                        wr_en    = 1'b1;
                        wr_addr  = IDX_W'(req_entry_index);
                        wr_data  = req_rec;
                        max_in   = '0;
                        ptr_in   = '0;
                        iss_in   = 1'b1;
                        state_in = S_SCAN;
                     end
                     default: begin
                        ptr_in   = IDX_W'(req_entry_index);
                        iss_in   = 1'b1;
                        state_in = S_RDW;
                     end
                  endcase
               end
            end
         end

         S_FIND: begin
            if (iss_ff) begin
               if (ptr_last) iss_in = 1'b0;
               else          ptr_in = ptr_ff + IDX_W'(1);
            end
            if (dv_ff) begin
               if ((in_run_ff || cmp.year_ge) && cmp.past_key) begin
                  pos_in   = CNT_W'(dptr_ff);
                  ptr_in   = IDX_W'(last_cnt);
                  iss_in   = 1'b1;
                  state_in = S_SHUP;
               end else if (dptr_last) begin
                  pos_in   = count_ff;
                  iss_in   = 1'b0;
                  state_in = S_NEW;
               end else begin
                  in_run_in = in_run_ff || cmp.year_ge;
               end
            end
         end

         S_SHUP: begin
            if (iss_ff) begin
               if (CNT_W'(ptr_ff) == pos_ff) iss_in = 1'b0;
               else                          ptr_in = ptr_ff - IDX_W'(1);
            end
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = dptr_ff + IDX_W'(1);
               wr_data = rd_data;
               if (CNT_W'(dptr_ff) == pos_ff) begin
                  state_in = S_NEW;
               end
            end
         end

         S_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = IDX_W'(pos_ff);
            wr_data  = new_ff;
            count_in = count_ff + CNT_W'(1);
            max_in   = '0;
            ptr_in   = '0;
            iss_in   = 1'b1;
            state_in = S_SCAN;
         end

         S_SHDN: begin
            if (iss_ff) begin
               if (ptr_last) iss_in = 1'b0;
               else          ptr_in = ptr_ff + IDX_W'(1);
            end
            if (dv_ff) begin
               wr_en   = 1'b1;
               wr_addr = dptr_ff - IDX_W'(1);
               wr_data = rd_data;
               if (dptr_last) begin
                  count_in = last_cnt;
                  max_in   = '0;
                  ptr_in   = '0;
                  iss_in   = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (iss_ff) begin
               if (ptr_last) iss_in = 1'b0;
               else          ptr_in = ptr_ff + IDX_W'(1);
            end
            if (dv_ff) begin
               if (cmp.amt_gt) max_in = rd_data.amount;
               if (dptr_last) begin
                  iss_in   = 1'b0;
                  state_in = S_DONE;
               end
            end
         end

         S_RDW: begin
            iss_in = 1'b0;
            if (dv_ff) begin
               rd_rec_in = rd_data;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
            iss_in   = 1'b0;
         end
      endcase
   end

   // read data is only consumed by the state that issued it
   assign dv_in   = iss_ff && (state_in == state_ff);
   assign dptr_in = ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         max_ff   <= '0;
         iss_ff   <= 1'b0;
         dv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         max_ff   <= max_in;
         iss_ff   <= iss_in;
         dv_ff    <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      new_ff    <= new_in;
      pos_ff    <= pos_in;
      ptr_ff    <= ptr_in;
      dptr_ff   <= dptr_in;
      in_run_ff <= in_run_in;
      status_ff <= status_in;
      rd_rec_ff <= rd_rec_in;
   end

   always_comb begin
      result.status     = status_ff;
      result.count      = count_ff;
      result.max_amount = max_ff;
      result.rec        = rd_rec_ff;
   end

endmodule

// ===== rtl/core/sorted_record_table.sv =====
// Sequence per request: error requests go straight to the result, reads fetch
//   one entry; change writes and rescans; delete shifts later entries down and
//   rescans; insert does slot search, shift up and rescan.
// Throughput: one request at a time, the next taken once the sequencer is
//   back in idle; one store entry walked per cycle. A result may wait.
// Reset: synchronous, active high; clears count and max; store not cleared.
// ----------------------------------------------------------------------------
// sorted_record_table: table of (year, month, amount) records, sorted on insert
// Insert sorted, delete at index, change at index and read at index, with
// count and exact largest amount reported on every result.
// ----------------------------------------------------------------------------
module sorted_record_table (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [srt_pkg::KIND_W-1:0]    req_kind,
   input  logic [srt_pkg::ENTRY_W-1:0]   req_entry_index,
   input  logic [srt_pkg::YEAR_W-1:0]    req_rec_year,
   input  logic [srt_pkg::MONTH_W-1:0]   req_rec_month,
   input  logic [srt_pkg::AMT_W-1:0]     req_rec_amount,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [srt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [srt_pkg::COUNT_OUT_W-1:0] rsp_count_now,
   output logic [srt_pkg::AMT_W-1:0]     rsp_max_amount,
   output logic [srt_pkg::YEAR_W-1:0]    rsp_out_year,
   output logic [srt_pkg::MONTH_W-1:0]   rsp_out_month,
   output logic [srt_pkg::AMT_W-1:0]     rsp_out_amount
);
   import srt_pkg::*;

   logic     rsp_valid_ff, rsp_valid_in;
   res_type  rsp_ff, rsp_in;
   logic     out_free;
   logic     done;
   res_type  result;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // sequencer: slot search, shifts and max rescan over the store
   srt_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_rec_year    (req_rec_year),
      .req_rec_month   (req_rec_month),
      .req_rec_amount  (req_rec_amount),
      .out_free        (out_free),
      .done            (done),
      .result          (result)
   );

   // result register: loaded when the sequencer finishes a request
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_count_now  = COUNT_OUT_W'(rsp_ff.count);
   assign rsp_max_amount = rsp_ff.max_amount;
   assign rsp_out_year   = rsp_ff.rec.year;
   assign rsp_out_month  = rsp_ff.rec.month;
   assign rsp_out_amount = rsp_ff.rec.amount;

endmodule

// ===== rtl/core/srt_checker.sv =====
// ----------------------------------------------------------------------------
// srt_checker: port-level checks of the sorted record table
// Watches the request and result channels only.
// ----------------------------------------------------------------------------
module srt_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [srt_pkg::STATUS_W-1:0]    rsp_status,
   input  logic [srt_pkg::COUNT_OUT_W-1:0] rsp_count_now,
   input  logic [srt_pkg::AMT_W-1:0]       rsp_max_amount,
   input  logic [srt_pkg::YEAR_W-1:0]      rsp_out_year,
   input  logic [srt_pkg::MONTH_W-1:0]     rsp_out_month,
   input  logic [srt_pkg::AMT_W-1:0]       rsp_out_amount
);
   import srt_pkg::*;

   // a request keeps the block busy for at least the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in flight");

   // full status only when the table holds DEPTH records
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |->
      (32'(rsp_count_now) == 32'(DEPTH)))
      else $error("full status with table not full");

   // failed requests return zero read fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STAT_OK) |->
      (rsp_out_year == '0 && rsp_out_month == '0 && rsp_out_amount == '0))
      else $error("read fields set on failed request");

   // an empty table has no maximum
   a_empty_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_count_now == '0) |-> (rsp_max_amount == '0))
      else $error("nonzero max with empty table");

   // a pending result holds its status
   a_hold_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("result dropped or changed while stalled");

endmodule

bind sorted_record_table srt_checker u_srt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_count_now  (rsp_count_now),
   .rsp_max_amount (rsp_max_amount),
   .rsp_out_year   (rsp_out_year),
   .rsp_out_month  (rsp_out_month),
   .rsp_out_amount (rsp_out_amount)
);

// ===== tb/record_table_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// record_table_checker: result predictor and comparator for the record table
// Tracks every accepted request, keeps its own copy of the sorted table and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module record_table_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [srt_pkg::KIND_W-1:0]      req_kind,
   input  logic [srt_pkg::ENTRY_W-1:0]     req_entry_index,
   input  logic [srt_pkg::YEAR_W-1:0]      req_rec_year,
   input  logic [srt_pkg::MONTH_W-1:0]     req_rec_month,
   input  logic [srt_pkg::AMT_W-1:0]       req_rec_amount,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [srt_pkg::STATUS_W-1:0]    rsp_status,
   input  logic [srt_pkg::COUNT_OUT_W-1:0] rsp_count_now,
   input  logic [srt_pkg::AMT_W-1:0]       rsp_max_amount,
   input  logic [srt_pkg::YEAR_W-1:0]      rsp_out_year,
   input  logic [srt_pkg::MONTH_W-1:0]     rsp_out_month,
   input  logic [srt_pkg::AMT_W-1:0]       rsp_out_amount,
   output int                              mismatches,
   output int                              pending,
   output int                              fill
);
   import srt_pkg::*;

   rec_type          stored_rec [DEPTH];
   int unsigned      held;
   logic [AMT_W-1:0] peak;
   res_type          awaited_results [$];
   res_type          want;
   int               errors;

   function automatic void rescan_peak();
      int unsigned p;
      peak = '0;
      for (p = 0; p < held; p++)
         if (stored_rec[p].amount > peak) peak = stored_rec[p].amount;
   endfunction

   // applies one request to the table copy and returns the result it gives
   function automatic res_type update_table(kind_type k, logic [ENTRY_W-1:0] idx,
                                            rec_type rec);
      res_type     r;
      int unsigned lo, hi, slot, p;
      r.status = STAT_OK;
      r.rec    = '0;
      if (k == KIND_INSERT) begin
         if (held >= DEPTH) begin
            r.status = STAT_FULL;
         end else begin
            // first year >= key, then scan that run for a later month
            lo = 0;
            while (lo < held && stored_rec[lo].year < rec.year) lo++;
            hi = lo;
            while (hi < held && stored_rec[hi].year <= rec.year) hi++;
            slot = lo;
            while (slot < hi && stored_rec[slot].month <= rec.month) slot++;
            for (p = held; p > slot; p--) stored_rec[p] = stored_rec[p-1];
            stored_rec[slot] = rec;
            held++;
            rescan_peak();
         end
      end else if (32'(idx) >= held) begin
         r.status = STAT_BAD_IDX;
      end else begin
         case (k)
            KIND_DELETE: begin
               for (p = 32'(idx); p + 1 < held; p++) stored_rec[p] = stored_rec[p+1];
               held--;
               rescan_peak();
            end
            KIND_CHANGE: begin
               stored_rec[idx] = rec;
               rescan_peak();
            end
            default: begin
               r.rec = stored_rec[idx];
            end
         endcase
      end
      r.count      = held[CNT_W-1:0];
      r.max_amount = peak;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held = 0;
         peak = '0;
         awaited_results.delete();
         pending <= 0;
         fill    <= 0;
      end else begin
         // result first: a request taken at this edge cannot answer here
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("count_now", 32'(want.count), 32'(rsp_count_now));
               check_field("max_amount", 32'(want.max_amount), 32'(rsp_max_amount));
               check_field("out_year", 32'(want.rec.year), 32'(rsp_out_year));
               check_field("out_month", 32'(want.rec.month), 32'(rsp_out_month));
               check_field("out_amount", 32'(want.rec.amount), 32'(rsp_out_amount));
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(update_table(kind_type'(req_kind), req_entry_index,
               rec_type'({req_rec_year, req_rec_month, req_rec_amount})));
         pending <= awaited_results.size();
         fill    <= int'(held);
      end
      mismatches <= errors;
   end

endmodule

// ===== tb/sorted_record_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_record_table_test: top level of the sorted record table bench
// Drives a directed opening and a long random run of insert, delete, change
// and read requests with random idling on both channels; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sorted_record_table_test;
   import srt_pkg::*;

   localparam int RANDOM_REQS = 2000;
   localparam int PHASE_LEN   = 200;   // requests per fill or drain stretch
   localparam int TAIL_CYCLES = 3 * DEPTH + 10;
   localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind = '0;
   logic [ENTRY_W-1:0]     req_entry_index = '0;
   logic [YEAR_W-1:0]      req_rec_year = '0;
   logic [MONTH_W-1:0]     req_rec_month = '0;
   logic [AMT_W-1:0]       req_rec_amount = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_count_now;
   logic [AMT_W-1:0]       rsp_max_amount;
   logic [YEAR_W-1:0]      rsp_out_year;
   logic [MONTH_W-1:0]     rsp_out_month;
   logic [AMT_W-1:0]       rsp_out_amount;

   int  mismatches;
   int  pending;     // results still owed by the block
   int  fill;        // predicted record count, used to aim indices
   int  stall_left = 0;
   int  quiet_cycles = 0;
   bit  steady = 1'b0;  // no idling on either side while set

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sorted_record_table dut (.*);

   record_table_checker u_checker (.*);

   // idle length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side backpressure, changed only on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // watchdog: any accepted request or result counts as progress
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("sorted_record_table_test: done, errors");
            $finish;
         end
      end
   end

   // moves to the next falling edge, dropping valid for a random gap;
   // returns at a falling edge where the next request may be driven
   task automatic idle_gap();
      int g;
      @(negedge clock);
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   // called at a falling edge; holds the request until it is taken
   task automatic send_request(kind_type k, logic [ENTRY_W-1:0] idx,
                               logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                               logic [AMT_W-1:0] amt);
      req_valid       <= 1'b1;
      req_kind        <= k;
      req_entry_index <= idx;
      req_rec_year    <= yr;
      req_rec_month   <= mo;
      req_rec_amount  <= amt;
      do @(posedge clock); while (!req_ready);
   endtask

   // sender holds off until every outstanding result is back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned        n, r;
      kind_type           k;
      logic [ENTRY_W-1:0] idx;
      logic [YEAR_W-1:0]  yr;
      logic [MONTH_W-1:0] mo;
      logic [AMT_W-1:0]   amt;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table: every indexed op is out of range
      idle_gap(); send_request(KIND_READ,   0,  0,    0,  24'd0);
      idle_gap(); send_request(KIND_DELETE, 0,  0,    0,  24'd0);
      idle_gap(); send_request(KIND_CHANGE, 63, 12,   4,  24'd5);
      // equal keys land after existing ones; field extremes
      idle_gap(); send_request(KIND_INSERT, 0,  2000, 6,  24'd100);
      idle_gap(); send_request(KIND_INSERT, 0,  2000, 6,  24'd200);
      idle_gap(); send_request(KIND_INSERT, 63, 0,    1,  24'd0);
      idle_gap(); send_request(KIND_INSERT, 0,  4095, 12, 24'hFFFFFF);
      idle_gap(); send_request(KIND_INSERT, 0,  2000, 3,  24'd50);
      idle_gap(); send_request(KIND_INSERT, 0,  2000, 9,  24'hFFFFFE);
      // months outside 1..12 are stored as given
      idle_gap(); send_request(KIND_INSERT, 0,  1999, 0,  24'd7);
      idle_gap(); send_request(KIND_INSERT, 0,  2001, 15, 24'd9);
      // reads, including last valid index and index equal to count
      idle_gap(); send_request(KIND_READ,   1,  0,    0,  24'd0);
      idle_gap(); send_request(KIND_READ,   3,  0,    0,  24'd0);
      idle_gap(); send_request(KIND_READ,   7,  0,    0,  24'd0);
      idle_gap(); send_request(KIND_READ,   8,  0,    0,  24'd0);
      // change the largest entry down: max must fall, order breaks
      idle_gap(); send_request(KIND_CHANGE, 7,  10,   5,  24'd3);
      idle_gap(); send_request(KIND_INSERT, 0,  2000, 6,  24'd300);
      idle_gap(); send_request(KIND_DELETE, 0,  0,    0,  24'd0);
      idle_gap(); send_request(KIND_DELETE, 7,  0,    0,  24'd0);
      idle_gap(); send_request(KIND_READ,   63, 0,    0,  24'd0);
      idle_gap(); send_request(KIND_DELETE, 63, 0,    0,  24'd0);
      // change raises the max
      idle_gap(); send_request(KIND_CHANGE, 0,  4095, 12, 24'hFFFFFF);
      idle_gap(); send_request(KIND_READ,   0,  0,    0,  24'd0);

      drain_results();

      // random run: alternate fill-heavy and drain-heavy stretches so the
      // table hits both full and empty
      for (n = 0; n < RANDOM_REQS; n++) begin
         steady = (n >= 700 && n < 900);
         if (n % 500 == 250) drain_results();
         idle_gap();
         r = $urandom_range(0, 99);
         if ((n / PHASE_LEN) % 2 == 0)
            k = (r < 55) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
                (r < 85) ? KIND_CHANGE : KIND_READ;
         else
            k = (r < 15) ? KIND_INSERT : (r < 70) ? KIND_DELETE :
                (r < 85) ? KIND_CHANGE : KIND_READ;
         // mostly aim inside the table, sometimes anywhere
         if (fill > 0 && $urandom_range(0, 99) < 85)
            idx = ENTRY_W'($urandom_range(0, fill - 1));
         else
            idx = ENTRY_W'($urandom_range(0, 63));
         // a narrow year band makes equal keys common
         yr  = ($urandom_range(0, 1) == 0) ? YEAR_W'(2000 + $urandom_range(0, 3))
                                           : YEAR_W'($urandom);
         mo  = ($urandom_range(0, 99) < 80) ? MONTH_W'($urandom_range(1, 12))
                                            : MONTH_W'($urandom);
         r   = $urandom_range(0, 19);
         amt = (r == 0) ? '0 : (r == 1) ? '1 : AMT_W'($urandom);
         send_request(k, idx, yr, mo, amt);
      end
      steady = 1'b0;

      // wind down and let the block settle
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("sorted_record_table_test: done, clean");
      else
         $display("sorted_record_table_test: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/srt_pkg.sv
rtl/core/srt_ram.sv
rtl/core/srt_cmp.sv
rtl/core/srt_seq.sv
rtl/core/sorted_record_table.sv
rtl/core/srt_checker.sv
tb/record_table_checker.sv
tb/sorted_record_table_test.sv
